// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file of this project.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/qpt_pkg.sv -----
// Types and constants of the quaternion point transform unit.
// Used by the top level, its checker and the testbench; depends on nothing else.
package qpt_pkg;

	localparam int VEC_W   = 32;
	localparam int QUAT_W  = 16;
	localparam int QPROD_W = 2 * QUAT_W;
	localparam int MAT_W   = 35;
	localparam int ENT_SH  = 14;
	localparam int ENT_W   = 20;
	localparam int PROD_W  = ENT_W + VEC_W;
	localparam int ACC_W   = PROD_W + 2;
	localparam int OUT_SH  = 14;
	localparam int SH_W    = ACC_W - OUT_SH;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W   = 32;
	localparam int NUM_AXES = 3;
	localparam int DATA_W  = NUM_AXES * VEC_W;

	localparam logic signed [MAT_W-1:0] ONE_Q28 = MAT_W'(1) <<< 28;
	localparam logic signed [QUAT_W-1:0] ONE_Q14 = QUAT_W'(16384);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROT_X    = 3'd0,
		REG_ROT_Y    = 3'd1,
		REG_ROT_Z    = 3'd2,
		REG_ROT_W    = 3'd3,
		REG_OFFSET_X = 3'd4,
		REG_OFFSET_Y = 3'd5,
		REG_OFFSET_Z = 3'd6
	} cfg_reg_t;

	typedef logic signed [VEC_W-1:0] vec_t [NUM_AXES];
	typedef logic signed [ENT_W-1:0] mat_t [NUM_AXES*NUM_AXES];
	typedef logic signed [PROD_W-1:0] prod_t [NUM_AXES*NUM_AXES];

	typedef struct packed {
		logic signed [QPROD_W-1:0] xx;
		logic signed [QPROD_W-1:0] yy;
		logic signed [QPROD_W-1:0] zz;
		logic signed [QPROD_W-1:0] xy;
		logic signed [QPROD_W-1:0] xz;
		logic signed [QPROD_W-1:0] yz;
		logic signed [QPROD_W-1:0] wx;
		logic signed [QPROD_W-1:0] wy;
		logic signed [QPROD_W-1:0] wz;
	} qprod_t;

	localparam logic signed [VEC_W-1:0] VEC_MAX = {1'b0, {(VEC_W-1){1'b1}}};
	localparam logic signed [VEC_W-1:0] VEC_MIN = {1'b1, {(VEC_W-1){1'b0}}};

	function automatic logic signed [VEC_W-1:0] sat_add(
		input logic signed [VEC_W-1:0] a,
		input logic signed [VEC_W-1:0] b
	);
		logic signed [VEC_W:0] sum;
		sum = (VEC_W+1)'(a) + (VEC_W+1)'(b);
		if (sum[VEC_W] != sum[VEC_W-1]) begin
			return sum[VEC_W] ? VEC_MIN : VEC_MAX;
		end
		return sum[VEC_W-1:0];
	endfunction

	function automatic logic signed [VEC_W-1:0] sat_out(input logic signed [SH_W-1:0] v);
		if (v > SH_W'(VEC_MAX)) begin
			return VEC_MAX;
		end
		if (v < SH_W'(VEC_MIN)) begin
			return VEC_MIN;
		end
		return v[VEC_W-1:0];
	endfunction

	function automatic logic signed [MAT_W-1:0] dbl(input logic signed [QPROD_W-1:0] p);
		return MAT_W'(p) <<< 1;
	endfunction

endpackage

// ----- rtl/quaternion_point_transform_unit.sv -----
// Top level of the quaternion point transform unit: offset, rotation matrix and product pipeline.
// Depends on qpt_pkg.
//
//   channel   direction  payload
//   s_axis    in         tuser: action; tdata: vec_x, vec_y, vec_z
//   m_axis    out        tdata: out_x, out_y, out_z
//   cfg       in         cfg_index selects the register, cfg_data carries its value
//
// Four register stages: offset and quaternion products, matrix entries, entry times
// component products, sums with saturation. One request can be taken every cycle while
// the output is not stalled. Reset clears the stage valid bits and loads the identity
// rotation with zero offset. A stalled output holds its stage while empty stages upstream
// keep filling, so no request is lost or repeated.
module quaternion_point_transform_unit
	import qpt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [DATA_W-1:0]    s_axis_tdata,  // vec_x, vec_y, vec_z from the lowest bit up
	input  logic                 s_axis_tuser,  // action
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [DATA_W-1:0]    m_axis_tdata,  // out_x, out_y, out_z from the lowest bit up
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic signed [QUAT_W-1:0] rot_x_q, rot_y_q, rot_z_q, rot_w_q;
	logic signed [VEC_W-1:0]  offset_x_q, offset_y_q, offset_z_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	vec_t   vec_s1, vec_s2;
	qprod_t qp_s1;
	mat_t   mat_s2;
	prod_t  prod_s3;
	vec_t   res_s4;

	logic signed [MAT_W-1:0] mat_full [NUM_AXES*NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_x_q    <= '0;
			rot_y_q    <= '0;
			rot_z_q    <= '0;
			rot_w_q    <= ONE_Q14;
			offset_x_q <= '0;
			offset_y_q <= '0;
			offset_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROT_X:    rot_x_q    <= cfg_data[QUAT_W-1:0];
				REG_ROT_Y:    rot_y_q    <= cfg_data[QUAT_W-1:0];
				REG_ROT_Z:    rot_z_q    <= cfg_data[QUAT_W-1:0];
				REG_ROT_W:    rot_w_q    <= cfg_data[QUAT_W-1:0];
				REG_OFFSET_X: offset_x_q <= cfg_data[VEC_W-1:0];
				REG_OFFSET_Y: offset_y_q <= cfg_data[VEC_W-1:0];
				REG_OFFSET_Z: offset_z_q <= cfg_data[VEC_W-1:0];
				default: ;
			endcase
		end
	end

	assign rdy_s4        = !vld_s4 || m_axis_tready;
	assign rdy_s3        = !vld_s3 || rdy_s4;
	assign rdy_s2        = !vld_s2 || rdy_s3;
	assign rdy_s1        = !vld_s1 || rdy_s2;
	assign s_axis_tready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= s_axis_tvalid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy_s4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_axis_tvalid) begin
			if (s_axis_tuser) begin
				vec_s1[0] <= sat_add(s_axis_tdata[0*VEC_W +: VEC_W], offset_x_q);
				vec_s1[1] <= sat_add(s_axis_tdata[1*VEC_W +: VEC_W], offset_y_q);
				vec_s1[2] <= sat_add(s_axis_tdata[2*VEC_W +: VEC_W], offset_z_q);
			end else begin
				vec_s1[0] <= s_axis_tdata[0*VEC_W +: VEC_W];
				vec_s1[1] <= s_axis_tdata[1*VEC_W +: VEC_W];
				vec_s1[2] <= s_axis_tdata[2*VEC_W +: VEC_W];
			end
			qp_s1.xx <= rot_x_q * rot_x_q;
			qp_s1.yy <= rot_y_q * rot_y_q;
			qp_s1.zz <= rot_z_q * rot_z_q;
			qp_s1.xy <= rot_x_q * rot_y_q;
			qp_s1.xz <= rot_x_q * rot_z_q;
			qp_s1.yz <= rot_y_q * rot_z_q;
			qp_s1.wx <= rot_w_q * rot_x_q;
			qp_s1.wy <= rot_w_q * rot_y_q;
			qp_s1.wz <= rot_w_q * rot_z_q;
		end
	end

	always_comb begin
		mat_full[0] = ONE_Q28 - (dbl(qp_s1.yy) + dbl(qp_s1.zz));
		mat_full[1] = dbl(qp_s1.xy) - dbl(qp_s1.wz);
		mat_full[2] = dbl(qp_s1.xz) + dbl(qp_s1.wy);
		mat_full[3] = dbl(qp_s1.xy) + dbl(qp_s1.wz);
		mat_full[4] = ONE_Q28 - (dbl(qp_s1.xx) + dbl(qp_s1.zz));
		mat_full[5] = dbl(qp_s1.yz) - dbl(qp_s1.wx);
		mat_full[6] = dbl(qp_s1.xz) - dbl(qp_s1.wy);
		mat_full[7] = dbl(qp_s1.yz) + dbl(qp_s1.wx);
		mat_full[8] = ONE_Q28 - (dbl(qp_s1.xx) + dbl(qp_s1.yy));
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			vec_s2 <= vec_s1;
			for (int i = 0; i < NUM_AXES*NUM_AXES; i++) begin
				mat_s2[i] <= mat_full[i][ENT_SH +: ENT_W];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			for (int r = 0; r < NUM_AXES; r++) begin
				for (int c = 0; c < NUM_AXES; c++) begin
					prod_s3[r*NUM_AXES+c] <= PROD_W'(mat_s2[r*NUM_AXES+c]) * PROD_W'(vec_s2[c]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4 && vld_s3) begin
			for (int r = 0; r < NUM_AXES; r++) begin
				res_s4[r] <= sat_out(SH_W'((ACC_W'(prod_s3[r*NUM_AXES])
					+ ACC_W'(prod_s3[r*NUM_AXES+1])
					+ ACC_W'(prod_s3[r*NUM_AXES+2])) >>> OUT_SH));
			end
		end
	end

	assign m_axis_tvalid = vld_s4;
	assign m_axis_tdata  = {res_s4[2], res_s4[1], res_s4[0]};

endmodule

// ----- rtl/qpt_checker.sv -----
// Port-level checker for the quaternion point transform unit, bound to its top level.
// Depends on qpt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qpt_checker
	import qpt_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_axis_tready,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [DATA_W-1:0]    m_axis_tdata
);

	`ASSERT_NEXT(a_out_valid_held, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "valid dropped")
	`ASSERT_NEXT(a_out_data_held, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "data moved")
	`ASSERT_SAME(a_empty_accepts, !m_axis_tvalid, s_axis_tready, "input refused while empty")
	`ASSERT_SAME(a_backpressure_cause, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "stray stall")

endmodule

bind quaternion_point_transform_unit qpt_checker u_qpt_checker (.*);

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// Testbench of quaternion_point_transform_unit: vector requests in random bursts, each checked
// against a bit-exact rotation predictor kept in step with the configuration writes.
// Depends on qpt_pkg and the unit's RTL; reads nothing at run time.
module tb;
	import qpt_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam logic signed [QUAT_W-1:0] QUAT_MAX = {1'b0, {(QUAT_W-1){1'b1}}};
	localparam logic signed [QUAT_W-1:0] QUAT_MIN = {1'b1, {(QUAT_W-1){1'b0}}};
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 12;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_ITEMS = 175;

	typedef struct packed {
		logic             point;
		logic [VEC_W-1:0] z;
		logic [VEC_W-1:0] y;
		logic [VEC_W-1:0] x;
	} vec_req_t;

	typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_THIRD, READY_RARELY} ready_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [DATA_W-1:0]    s_axis_tdata = '0;
	logic                 s_axis_tuser = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [DATA_W-1:0]    m_axis_tdata;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;

	logic signed [QUAT_W-1:0] q_x, q_y, q_z, q_w;
	logic signed [VEC_W-1:0]  off_x, off_y, off_z;

	vec_req_t          pending_vectors [$];
	logic [DATA_W-1:0] rotated_due [$];
	int                fail_count = 0;
	int                cycle_count = 0;
	int                burst_left = 1;
	int                gap_left = 0;
	ready_mode_t       ready_mode = READY_ALWAYS;
	int                ready_left = 0;
	int                ready_tick = 0;
	string             axis_tag [NUM_AXES] = '{"x", "y", "z"};

	quaternion_point_transform_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic longint sat_to_vec(input longint v);
		if (v > longint'(VEC_MAX)) begin
			return longint'(VEC_MAX);
		end
		if (v < longint'(VEC_MIN)) begin
			return longint'(VEC_MIN);
		end
		return v;
	endfunction

	function automatic logic [DATA_W-1:0] rotate_vector(input vec_req_t req);
		longint v [NUM_AXES];
		longint ent [NUM_AXES*NUM_AXES];
		longint qx, qy, qz, qw;
		longint dxx, dyy, dzz, dxy, dxz, dyz, dwx, dwy, dwz;
		longint one, acc, clipped;
		logic [DATA_W-1:0] rotated;
		v[0] = longint'($signed(req.x));
		v[1] = longint'($signed(req.y));
		v[2] = longint'($signed(req.z));
		if (req.point) begin
			v[0] = sat_to_vec(v[0] + longint'(off_x));
			v[1] = sat_to_vec(v[1] + longint'(off_y));
			v[2] = sat_to_vec(v[2] + longint'(off_z));
		end
		qx = q_x;
		qy = q_y;
		qz = q_z;
		qw = q_w;
		dxx = 2 * qx * qx;
		dyy = 2 * qy * qy;
		dzz = 2 * qz * qz;
		dxy = 2 * qx * qy;
		dxz = 2 * qx * qz;
		dyz = 2 * qy * qz;
		dwx = 2 * qw * qx;
		dwy = 2 * qw * qy;
		dwz = 2 * qw * qz;
		one = longint'(1) <<< 28;
		ent[0] = one - (dyy + dzz);
		ent[1] = dxy - dwz;
		ent[2] = dxz + dwy;
		ent[3] = dxy + dwz;
		ent[4] = one - (dxx + dzz);
		ent[5] = dyz - dwx;
		ent[6] = dxz - dwy;
		ent[7] = dyz + dwx;
		ent[8] = one - (dxx + dyy);
		for (int i = 0; i < NUM_AXES * NUM_AXES; i++) begin
			ent[i] = ent[i] >>> ENT_SH;
		end
		for (int a = 0; a < NUM_AXES; a++) begin
			acc = ent[3*a] * v[0] + ent[3*a+1] * v[1] + ent[3*a+2] * v[2];
			clipped = sat_to_vec(acc >>> OUT_SH);
			rotated[a*VEC_W +: VEC_W] = clipped[VEC_W-1:0];
		end
		return rotated;
	endfunction

	function automatic void add_vector(input logic p, input logic [VEC_W-1:0] vx,
			input logic [VEC_W-1:0] vy, input logic [VEC_W-1:0] vz);
		pending_vectors.push_back('{point: p, x: vx, y: vy, z: vz});
	endfunction

	function automatic logic [VEC_W-1:0] random_component();
		logic signed [19:0] modest;
		modest = 20'($urandom);
		case ($urandom_range(0, 7))
			0: return VEC_MAX;
			1: return VEC_MIN;
			2: return '0;
			3, 4: return {{(VEC_W-20){modest[19]}}, modest};
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [QUAT_W-1:0] random_quat_part();
		case ($urandom_range(0, 5))
			0: return QUAT_MAX;
			1: return QUAT_MIN;
			2: return '0;
			default: return QUAT_W'($urandom);
		endcase
	endfunction

	// Sender: bursts of random length separated by random gaps; prediction at acceptance.
	always @(posedge clk) begin
		vec_req_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				rotated_due.push_back(rotate_vector(vec_req_t'({s_axis_tuser, s_axis_tdata})));
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (gap_left > 0 || pending_vectors.size() == 0) begin
					if (gap_left > 0) begin
						gap_left--;
					end
					s_axis_tvalid <= 1'b0;
				end else begin
					nxt = pending_vectors.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= {nxt.z, nxt.y, nxt.x};
					s_axis_tuser <= nxt.point;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	// Receiver: compares each result with the oldest prediction and stalls by its own pattern.
	always @(posedge clk) begin
		logic [DATA_W-1:0] due;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (rotated_due.size() == 0) begin
					$display("%0t: result %h arrived with no request outstanding", $time,
						m_axis_tdata);
					fail_count++;
				end else begin
					due = rotated_due.pop_front();
					for (int a = 0; a < NUM_AXES; a++) begin
						if (m_axis_tdata[a*VEC_W +: VEC_W] !== due[a*VEC_W +: VEC_W]) begin
							$display("%0t: out_%s expected %h got %h", $time, axis_tag[a],
								due[a*VEC_W +: VEC_W], m_axis_tdata[a*VEC_W +: VEC_W]);
							fail_count++;
						end
					end
				end
			end
			if (ready_left == 0) begin
				ready_mode = ready_mode_t'($urandom_range(0, 3));
				ready_left = $urandom_range(40, 300);
			end
			ready_left--;
			ready_tick++;
			case (ready_mode)
				READY_ALWAYS: m_axis_tready <= 1'b1;
				READY_MOSTLY: m_axis_tready <= ($urandom_range(0, 9) < 7);
				READY_THIRD:  m_axis_tready <= (ready_tick % 3 == 0);
				default:      m_axis_tready <= ($urandom_range(0, 9) < 3);
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			q_x   <= '0;
			q_y   <= '0;
			q_z   <= '0;
			q_w   <= ONE_Q14;
			off_x <= '0;
			off_y <= '0;
			off_z <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROT_X:    q_x <= cfg_data[QUAT_W-1:0];
				REG_ROT_Y:    q_y <= cfg_data[QUAT_W-1:0];
				REG_ROT_Z:    q_z <= cfg_data[QUAT_W-1:0];
				REG_ROT_W:    q_w <= cfg_data[QUAT_W-1:0];
				REG_OFFSET_X: off_x <= cfg_data[VEC_W-1:0];
				REG_OFFSET_Y: off_y <= cfg_data[VEC_W-1:0];
				REG_OFFSET_Z: off_z <= cfg_data[VEC_W-1:0];
				default: ;
			endcase
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic program_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// The bits above the 16-bit value are random and must be dropped by the unit.
	task automatic program_quat(input logic [QUAT_W-1:0] x, input logic [QUAT_W-1:0] y,
			input logic [QUAT_W-1:0] z, input logic [QUAT_W-1:0] w);
		program_reg(REG_ROT_X, {(CFG_W-QUAT_W)'($urandom), x});
		program_reg(REG_ROT_Y, {(CFG_W-QUAT_W)'($urandom), y});
		program_reg(REG_ROT_Z, {(CFG_W-QUAT_W)'($urandom), z});
		program_reg(REG_ROT_W, {(CFG_W-QUAT_W)'($urandom), w});
	endtask

	task automatic program_offset(input logic [VEC_W-1:0] x, input logic [VEC_W-1:0] y,
			input logic [VEC_W-1:0] z);
		program_reg(REG_OFFSET_X, x);
		program_reg(REG_OFFSET_Y, y);
		program_reg(REG_OFFSET_Z, z);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_vectors.size() != 0 || rotated_due.size() != 0 || s_axis_tvalid) begin
			@(negedge clk);
		end
	endtask

	task automatic program_random_setup(input int phase);
		logic [QUAT_W-1:0] qv [4];
		real half_angle;
		int axis;
		if (phase % 2 == 0) begin
			for (int i = 0; i < 4; i++) begin
				qv[i] = random_quat_part();
			end
		end else begin
			half_angle = $urandom_range(0, 6283) / 2000.0;
			axis = $urandom_range(0, 2);
			for (int i = 0; i < 3; i++) begin
				qv[i] = '0;
			end
			qv[axis] = QUAT_W'($rtoi(16384.0 * $sin(half_angle)));
			qv[3] = QUAT_W'($rtoi(16384.0 * $cos(half_angle)));
		end
		program_quat(qv[0], qv[1], qv[2], qv[3]);
		program_offset(random_component(), random_component(), random_component());
		if ($urandom_range(0, 1) == 1) begin
			program_reg(REG_UNUSED, $urandom);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Identity rotation and zero offset straight out of reset.
		@(negedge clk);
		add_vector(1'b0, '0, '0, '0);
		add_vector(1'b1, VEC_MAX, VEC_MAX, VEC_MAX);
		add_vector(1'b0, VEC_MIN, VEC_MIN, VEC_MIN);
		add_vector(1'b1, 32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF);
		add_vector(1'b0, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_0001);
		wait_idle();

		// Quarter turn about z with offsets that overflow in both directions.
		program_quat('0, '0, 16'd11585, 16'd11585);
		program_offset(VEC_MAX, VEC_MIN, 32'h0001_0000);
		@(negedge clk);
		add_vector(1'b1, VEC_MAX, VEC_MIN, 32'h7FFF_0000);
		add_vector(1'b1, VEC_MIN, VEC_MAX, '0);
		add_vector(1'b0, VEC_MAX, VEC_MIN, 32'h1234_5678);
		add_vector(1'b1, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000);
		wait_idle();

		// Half turn about x negates y and z, saturating the most negative value; the stray write must change nothing.
		program_quat(ONE_Q14, '0, '0, '0);
		program_reg(REG_UNUSED, 32'hFFFF_FFFF);
		@(negedge clk);
		add_vector(1'b1, 32'h0003_0000, 32'h0004_0000, 32'h0005_0000);
		add_vector(1'b0, VEC_MIN, VEC_MIN, VEC_MIN);
		wait_idle();

		// Quaternions far from unit length scale the vector into saturation.
		program_quat(QUAT_MIN, QUAT_MIN, QUAT_MIN, QUAT_MIN);
		program_offset(VEC_MIN, VEC_MIN, VEC_MIN);
		@(negedge clk);
		add_vector(1'b1, VEC_MIN, VEC_MIN, VEC_MIN);
		add_vector(1'b0, VEC_MAX, VEC_MAX, VEC_MAX);
		add_vector(1'b0, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003);
		add_vector(1'b1, VEC_MAX, '0, VEC_MIN);
		wait_idle();

		program_quat(QUAT_MAX, QUAT_MAX, QUAT_MAX, QUAT_MAX);
		program_offset(VEC_MAX, VEC_MAX, VEC_MAX);
		@(negedge clk);
		add_vector(1'b1, VEC_MAX, VEC_MAX, VEC_MAX);
		add_vector(1'b0, VEC_MIN, VEC_MAX, '0);
		add_vector(1'b1, 32'h0000_0100, 32'hFFFF_FF00, 32'h0000_8000);
		wait_idle();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			program_random_setup(phase);
			@(negedge clk);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				add_vector(1'($urandom_range(0, 1)), random_component(), random_component(),
					random_component());
			end
			wait_idle();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
